FILE: rtl/core/adh_pkg.sv
// Shared constants and types for the axial density histogram.
package adh_pkg;

   localparam int BINS = 1024;
   localparam int BIN_BITS = $clog2(BINS);
   localparam int BIN_SHIFT = 32 - BIN_BITS;
   localparam int CNT_BITS = 32;
   localparam int DEN_BITS = 48;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_FRAME = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_BOX    = 2'd0,
      REG_INV    = 2'd1,
      REG_WEIGHT = 2'd2,
      REG_WINDOW = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_FIX,
      S_MUL,
      S_BIN,
      S_RMW_RD,
      S_RMW_WR,
      S_SWEEP,
      S_HRD,
      S_MUL_S,
      S_MUL_L,
      S_MUL_C,
      S_OUT
   } state_type;

endpackage

FILE: rtl/core/adh_ram.sv
// Generic single write, single read RAM with registered read data.
module adh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/axial_density_histogram.sv
// Two-species z density histogram with windowed hold and bin readout.
// Work per item: add atom (32-step remainder unit, multiply, bin read-modify-write);
// end of frame, with a copy and clear sweep when the window closes; read bin (RAM
// read, three passes through the shared multiplier).
// The result becomes valid as the block returns to idle; a waiting result holds input.
// After reset a clearing pass zeroes both stores; no item is accepted until it ends.
module axial_density_histogram (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // z_position[31:0], bin_index[41:32], zero
   input  logic [2:0]   req_tuser,  // operation[1:0], long_species[2]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [175:0] rsp_tdata,  // density_short[47:0], density_long[95:48],
                                    // density_total[144:96], bin_center_z[175:145]
   output logic [0:0]   rsp_tuser,  // window_done[0]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import adh_pkg::*;

   state_type state_ff, state_in;

   logic [30:0] box_ff;
   logic [31:0] inv_ff, weight_ff;
   logic [15:0] window_ff, frame_ff, frame_in;

   logic        long_ff, long_in, neg_ff, neg_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [30:0] rem_ff, rem_in, wrap_ff, wrap_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] prod_ff, prod_in;
   logic [BIN_BITS-1:0] addr_ff, addr_in;
   logic [BIN_BITS:0]   sweep_ff, sweep_in;

   logic        rvalid_ff, rvalid_in, wd_ff, wd_in;
   logic [47:0] ds_ff, ds_in, dl_ff, dl_in;
   logic [30:0] cz_ff, cz_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [47:0] mul_sat;

   logic                sum_we, sum_re, held_we, held_re;
   logic [BIN_BITS-1:0] sum_wa, sum_ra, held_wa, held_ra;
   logic [63:0]         sum_wd, sum_rd, held_wd, held_rd;

   logic [31:0] div_t;
   logic [32:0] div_d;
   logic [31:0] zmag, cnt_old;
   logic [16:0] frame_next;
   logic [41:0] bin_full;

   adh_ram #(.WIDTH(2 * CNT_BITS), .DEPTH(BINS)) u_sum_ram (
      .clock(clock), .wr_en(sum_we), .wr_addr(sum_wa), .wr_data(sum_wd),
      .rd_en(sum_re), .rd_addr(sum_ra), .rd_data(sum_rd)
   );

   adh_ram #(.WIDTH(2 * CNT_BITS), .DEPTH(BINS)) u_held_ram (
      .clock(clock), .wr_en(held_we), .wr_addr(held_wa), .wr_data(held_wd),
      .rd_en(held_re), .rd_addr(held_ra), .rd_data(held_rd)
   );

   assign mul_p   = 64'(mul_a) * 64'(mul_b);
   assign mul_sat = (mul_p[63:DEN_BITS] != '0) ? '1 : mul_p[DEN_BITS-1:0];

   assign div_t = {rem_ff, dvd_ff[31]};
   assign div_d = {1'b0, div_t} - {2'b00, box_ff};
   assign zmag  = req_tdata[31] ? (~req_tdata[31:0] + 32'd1) : req_tdata[31:0];
   assign frame_next = {1'b0, frame_ff} + 17'd1;
   assign bin_full = prod_ff[63:BIN_SHIFT];
   assign cnt_old = long_ff ? sum_rd[63:32] : sum_rd[31:0];

   assign req_tready = (state_ff == S_IDLE) && (!rvalid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = wd_ff;
   assign rsp_tdata  = {cz_ff, {1'b0, ds_ff} + {1'b0, dl_ff}, dl_ff, ds_ff};

   always_comb begin
      state_in  = state_ff;
      frame_in  = frame_ff;
      long_in   = long_ff;
      neg_in    = neg_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      wrap_in   = wrap_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      addr_in   = addr_ff;
      sweep_in  = sweep_ff;
      rvalid_in = rvalid_ff & ~rsp_tready;
      wd_in     = wd_ff;
      ds_in     = ds_ff;
      dl_in     = dl_ff;
      cz_in     = cz_ff;
      mul_a     = '0;
      mul_b     = '0;
      sum_we    = 1'b0;
      sum_wa    = sweep_ff[BIN_BITS-1:0];
      sum_wd    = '0;
      sum_re    = 1'b0;
      sum_ra    = addr_ff;
      held_we   = 1'b0;
      held_wa   = sweep_ff[BIN_BITS-1:0];
      held_wd   = '0;
      held_re   = 1'b0;
      held_ra   = addr_ff;

      case (state_ff)
         S_CLEAR: begin
            sum_we   = 1'b1;
            held_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (BIN_BITS+1)'(BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               long_in = req_tuser[2];
               neg_in  = req_tdata[31];
               dvd_in  = zmag;
               rem_in  = '0;
               cnt_in  = '1;
               wd_in   = 1'b0;
               ds_in   = '0;
               dl_in   = '0;
               cz_in   = '0;
               addr_in = (32'(req_tdata[41:32]) > 32'(BINS - 1)) ? BIN_BITS'(BINS - 1)
                                                                   : req_tdata[32 +: BIN_BITS];
               case (op_type'(req_tuser[1:0]))
                  OP_ADD:   state_in = S_DIV;
                  OP_FRAME: begin
                     if (frame_next >= {1'b0, window_ff}) begin
                        frame_in = '0;
                        wd_in    = 1'b1;
                        sweep_in = '0;
                        state_in = S_SWEEP;
                     end else begin
                        frame_in = frame_next[15:0];
                        state_in = S_OUT;
                     end
                  end
                  OP_READ:  state_in = S_HRD;
                  default:  state_in = S_OUT;
               endcase
            end
         end
         S_DIV: begin
            dvd_in = {dvd_ff[30:0], 1'b0};
            rem_in = div_d[32] ? div_t[30:0] : div_d[30:0];
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (box_ff == '0) begin
               wrap_in = '0;
            end else if (neg_ff && rem_ff != '0) begin
               wrap_in = box_ff - rem_ff;
            end else begin
               wrap_in = rem_ff;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            mul_a    = {1'b0, wrap_ff};
            mul_b    = inv_ff;
            prod_in  = mul_p;
            state_in = S_BIN;
         end
         S_BIN: begin
            addr_in  = (bin_full > 42'(BINS - 1)) ? BIN_BITS'(BINS - 1)
                                                 : bin_full[BIN_BITS-1:0];
            state_in = S_RMW_RD;
         end
         S_RMW_RD: begin
            sum_re   = 1'b1;
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            sum_we = 1'b1;
            sum_wa = addr_ff;
            sum_wd = sum_rd;
            if (cnt_old != '1) begin
               if (long_ff) begin
                  sum_wd[63:32] = cnt_old + 32'd1;
               end else begin
                  sum_wd[31:0] = cnt_old + 32'd1;
               end
            end
            state_in = S_OUT;
         end
         S_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff != (BIN_BITS+1)'(BINS)) begin
               sum_re = 1'b1;
               sum_ra = sweep_ff[BIN_BITS-1:0];
               sum_we = 1'b1;
            end else begin
               state_in = S_OUT;
            end
            if (sweep_ff != '0) begin
               held_we = 1'b1;
               held_wa = BIN_BITS'(sweep_ff - 1'b1);
               held_wd = sum_rd;
            end
         end
         S_HRD: begin
            held_re  = 1'b1;
            state_in = S_MUL_S;
         end
         S_MUL_S: begin
            mul_a    = held_rd[31:0];
            mul_b    = weight_ff;
            ds_in    = mul_sat;
            state_in = S_MUL_L;
         end
         S_MUL_L: begin
            mul_a    = held_rd[63:32];
            mul_b    = weight_ff;
            dl_in    = mul_sat;
            state_in = S_MUL_C;
         end
         S_MUL_C: begin
            mul_a    = 32'({addr_ff, 1'b1});
            mul_b    = {1'b0, box_ff};
            cz_in    = mul_p[BIN_BITS+1 +: 31];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         sweep_ff  <= '0;
         frame_ff  <= '0;
         rvalid_ff <= 1'b0;
         box_ff    <= 31'd65536;
         inv_ff    <= 32'd65536;
         weight_ff <= 32'd65536;
         window_ff <= 16'd1000;
      end else begin
         state_ff  <= state_in;
         sweep_ff  <= sweep_in;
         frame_ff  <= frame_in;
         rvalid_ff <= rvalid_in;
         if (csr_valid) begin
            case (reg_type'(csr_index))
               REG_BOX:    box_ff    <= csr_data[30:0];
               REG_INV:    inv_ff    <= csr_data;
               REG_WEIGHT: weight_ff <= csr_data;
               REG_WINDOW: window_ff <= csr_data[15:0];
               default:    ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      long_ff <= long_in;
      neg_ff  <= neg_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      wrap_ff <= wrap_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      addr_ff <= addr_in;
      wd_ff   <= wd_in;
      ds_ff   <= ds_in;
      dl_ff   <= dl_in;
      cz_ff   <= cz_in;
   end

endmodule

FILE: tb/axial_density_histogram_tb.sv
// Self-checking testbench for the axial density histogram: directed and random items.
module axial_density_histogram_tb;
   import adh_pkg::*;

   typedef struct packed {
      logic        done;
      logic [47:0] dens_short;
      logic [47:0] dens_long;
      logic [48:0] dens_total;
      logic [30:0] center_z;
   } profile_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [175:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   logic [31:0]  acc_short [BINS];
   logic [31:0]  acc_long [BINS];
   logic [31:0]  held_short [BINS];
   logic [31:0]  held_long [BINS];
   logic [15:0]  frames_seen;
   logic [30:0]  cfg_box;
   logic [31:0]  cfg_inv;
   logic [31:0]  cfg_weight;
   logic [15:0]  cfg_window;

   profile_row_type pending_rows[$];
   int           mismatches = 0;
   bit           steady = 1'b0;
   int           stall_left = 0;

   axial_density_histogram i_dut (.*);

   always #2 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [9:0] z_to_bin(logic [31:0] zbits);
      longint z;
      longint r;
      logic [63:0] t;
      logic [63:0] b;
      r = 0;
      if (cfg_box != 0) begin
         z = longint'(signed'(zbits));
         r = z % longint'(cfg_box);
         if (r < 0) r += longint'(cfg_box);
      end
      t = 64'(r) * 64'(cfg_inv);
      b = (t >> 32) * BINS + (((t & 64'hFFFF_FFFF) * BINS) >> 32);
      if (b > BINS - 1) b = BINS - 1;
      return b[9:0];
   endfunction

   function automatic logic [47:0] count_density(logic [31:0] count);
      logic [63:0] p;
      p = 64'(count) * 64'(cfg_weight);
      return (p > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : p[47:0];
   endfunction

   task automatic predict_row(op_type op, logic [31:0] z, logic species, logic [9:0] idx);
      profile_row_type row;
      logic [9:0]  b;
      logic [16:0] next;
      logic [63:0] c;
      row = '0;
      case (op)
         OP_ADD: begin
            b = z_to_bin(z);
            if (species) begin
               if (acc_long[b] != 32'hFFFF_FFFF) acc_long[b]++;
            end else begin
               if (acc_short[b] != 32'hFFFF_FFFF) acc_short[b]++;
            end
         end
         OP_FRAME: begin
            next = frames_seen + 17'd1;
            if (next >= cfg_window) begin
               held_short = acc_short;
               held_long = acc_long;
               foreach (acc_short[i]) begin
                  acc_short[i] = '0;
                  acc_long[i] = '0;
               end
               frames_seen = '0;
               row.done = 1'b1;
            end else begin
               frames_seen = next[15:0];
            end
         end
         OP_READ: begin
            row.dens_short = count_density(held_short[idx]);
            row.dens_long = count_density(held_long[idx]);
            row.dens_total = {1'b0, row.dens_short} + {1'b0, row.dens_long};
            c = ((2 * 64'(idx) + 1) * 64'(cfg_box)) / (2 * BINS);
            row.center_z = c[30:0];
         end
         default: ;
      endcase
      pending_rows = {pending_rows, row};
   endtask

   task automatic send_item(op_type op, logic [31:0] z, logic species, logic [9:0] idx);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, idx, z};
      req_tuser <= {species, op};
      do @(posedge clock); while (!req_tready);
      predict_row(op, z, species, idx);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rows.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic write_reg(reg_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_BOX:    cfg_box = value[30:0];
         REG_INV:    cfg_inv = value;
         REG_WEIGHT: cfg_weight = value;
         default:    cfg_window = value[15:0];
      endcase
      @(negedge clock);
   endtask

   task automatic set_box(logic [30:0] box, logic [31:0] inv, logic [31:0] weight,
                          logic [15:0] window);
      drain();
      write_reg(REG_BOX, {1'b0, box});
      write_reg(REG_INV, inv);
      write_reg(REG_WEIGHT, weight);
      write_reg(REG_WINDOW, {16'd0, window});
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int count);
      int r;
      logic [31:0] z;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 3) == 0) z = $urandom;
         else z = $urandom_range(0, 2 * cfg_box + 1) - cfg_box / 2;
         if (r < 58) send_item(OP_ADD, z, 1'($urandom_range(0, 1)), 10'($urandom));
         else if (r < 74) send_item(OP_FRAME, $urandom, 1'($urandom_range(0, 1)),
                                    10'($urandom));
         else if (r < 96) send_item(OP_READ, $urandom, 1'($urandom_range(0, 1)),
                                    10'($urandom));
         else send_item(OP_NONE, $urandom, 1'($urandom_range(0, 1)), 10'($urandom));
      end
   endtask

   task automatic test_defaults();
      send_item(OP_ADD, 32'h0000_8000, 1'b0, 10'd0);
      send_item(OP_READ, 32'h0, 1'b0, 10'd512);
      send_item(OP_FRAME, 32'h0, 1'b0, 10'd0);
      send_item(OP_NONE, 32'hFFFF_FFFF, 1'b1, 10'h3FF);
   endtask

   task automatic test_directed();
      set_box(31'd65536, 32'd65537, 32'd65536, 16'd0);
      send_item(OP_ADD, 32'h8000_0000, 1'b0, 10'd0);
      send_item(OP_ADD, 32'h7FFF_FFFF, 1'b1, 10'd0);
      send_item(OP_ADD, 32'h0000_FFFF, 1'b1, 10'd0);
      send_item(OP_ADD, 32'hFFFF_FFFF, 1'b0, 10'd0);
      send_item(OP_ADD, 32'h0, 1'b1, 10'd0);
      send_item(OP_FRAME, 32'h0, 1'b0, 10'd0);
      send_item(OP_READ, 32'h0, 1'b0, 10'd0);
      send_item(OP_READ, 32'h0, 1'b0, 10'h3FF);
      send_item(OP_NONE, 32'h1234_5678, 1'b1, 10'd7);
      set_box(31'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
      send_item(OP_ADD, 32'h1357_9BDF, 1'b0, 10'd0);
      send_item(OP_ADD, 32'hFFFF_0000, 1'b1, 10'd0);
      send_item(OP_FRAME, 32'h0, 1'b0, 10'd0);
      send_item(OP_READ, 32'h0, 1'b1, 10'd0);
      set_box(31'h7FFF_FFFF, 32'd3, 32'd0, 16'hFFFF);
      send_item(OP_ADD, 32'h7FFF_FFFF, 1'b0, 10'd0);
      send_item(OP_FRAME, 32'h0, 1'b0, 10'd0);
      send_item(OP_READ, 32'h0, 1'b0, 10'h3FF);
   endtask

   task automatic test_random();
      logic [30:0] box;
      for (int phase = 0; phase < 8; phase++) begin
         box = (phase == 7) ? 31'h7FFF_FFFF
                            : 31'($urandom_range(1, 1 << (12 + phase * 2)));
         steady = (phase == 3);
         set_box(box, 32'((33'h1_0000_0000 / box) + $urandom_range(0, 1)),
                 (phase == 5) ? 32'hFFFF_FFFF : $urandom, 16'($urandom_range(1, 4)));
         run_random(85);
      end
      steady = 1'b0;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
         stall_left <= $urandom_range(10, 40);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 70);
      end
   end

   always @(posedge clock) begin
      profile_row_type got;
      profile_row_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[0], rsp_tdata[47:0], rsp_tdata[95:48], rsp_tdata[144:96],
                rsp_tdata[175:145]};
         if (pending_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", got);
         end else begin
            want = pending_rows.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: done %b/%b short %h/%h long %h/%h total %h/%h z %h/%h",
                           want.done, got.done, want.dens_short, got.dens_short,
                           want.dens_long, got.dens_long, want.dens_total, got.dens_total,
                           want.center_z, got.center_z);
            end
         end
      end
   end

   initial begin
      foreach (acc_short[i]) begin
         acc_short[i] = '0;
         acc_long[i] = '0;
         held_short[i] = '0;
         held_long[i] = '0;
      end
      frames_seen = '0;
      cfg_box = 31'd65536;
      cfg_inv = 32'd65536;
      cfg_weight = 32'd65536;
      cfg_window = 16'd1000;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_defaults();
      test_directed();
      test_random();
      drain();
      if (mismatches == 0 && pending_rows.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/adh_pkg.sv
rtl/core/adh_ram.sv
rtl/core/axial_density_histogram.sv
tb/axial_density_histogram_tb.sv
